/* sv/fsnf_pkg.sv */
`timescale 1ns / 1ps

package fsnf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ARG_W           = 32;
  localparam int CHAR_W          = 8;
  localparam int CAP_W           = 16;
  localparam int CMD_W           = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_FMT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END = 2'd2;

  // Characters
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LC_B    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LC_C    = 8'h63;
  localparam logic [CHAR_W-1:0] CH_LC_D    = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LC_S    = 8'h73;
  localparam logic [CHAR_W-1:0] CH_LC_U    = 8'h75;
  localparam logic [CHAR_W-1:0] CH_LC_X    = 8'h78;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2
  } fsnf_base_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PRE    = 5'b00010,
    ST_DABBLE = 5'b00100,
    ST_STRIP  = 5'b01000,
    ST_DIGITS = 5'b10000
  } fsnf_state_t;

  typedef struct packed {
    logic load;       // latch input item and its decoded plan
    logic emit;       // write one character to the output register
    logic sel_digit;  // emit from the digit register, else from the prefix
    logic last;       // final character of the item
    logic dabble;     // one binary-to-BCD step
    logic bcd_load;   // move BCD digits into the digit register
    logic strip;      // drop one leading zero digit
  } fsnf_cmd_t;

  typedef struct packed {
    logic out_free;
    logic npre_zero;
    logic npre_one;
    logic has_num;
    logic is_dec;
    logic cnt_zero;
    logic cnt_one;
    logic top_zero;
  } fsnf_status_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage

/* sv/format_string_number_formatter.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_command[1:0], in_ch[7:0], in_arg_value[31:0]
// out_     output     out_valid/out_stall out_char[7:0], out_index[15:0], out_last,
//                                         out_overflow
// cfg_     input      cfg_valid/cfg_ready cfg_capacity[15:0]
//
// One item at a time: the sequencer accepts it, emits each prefix or plain character,
// then finishes. Numbers add the BCD conversion (decimal only), drop leading zero digits
// while more than one digit is left, and emit the digits one by one.
// Reset (synchronous, rst_n low) empties the output register and restores capacity 256.
// Stalls on out_ hold the sequencer; in_stall stays high until the item is done, and the
// next item is taken while the last result of the previous one still waits for out_.

module format_string_number_formatter #(
  parameter int VALUE_WIDTH = fsnf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // format / string item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fsnf_pkg::CMD_W-1:0]   in_command,
  input  logic [fsnf_pkg::CHAR_W-1:0]  in_ch,
  input  logic [fsnf_pkg::ARG_W-1:0]   in_arg_value,
  // character result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fsnf_pkg::CHAR_W-1:0]  out_char,
  output logic [fsnf_pkg::CAP_W-1:0]   out_index,
  output logic                         out_last,
  output logic                         out_overflow,
  // capacity register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fsnf_pkg::CAP_W-1:0]   cfg_capacity
);

  fsnf_pkg::fsnf_cmd_t    cmd;
  fsnf_pkg::fsnf_status_t status;

  // Capacity writes go straight into the capacity register; always take them.
  assign cfg_ready = 1'b1;

  // Sequencer: walks prefix characters, the BCD conversion, leading-zero
  // suppression and digit output for one item.
  fsnf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: item decode, digit shift register, BCD converter, buffer
  // position / sticky overflow tracking and the output register.
  fsnf_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_command   (in_command),
    .in_ch        (in_ch),
    .in_arg_value (in_arg_value),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_capacity),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_char     (out_char),
    .out_index    (out_index),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule

/* sv/fsnf_ctrl.sv */
`timescale 1ns / 1ps

module fsnf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  fsnf_pkg::fsnf_status_t status,
  output fsnf_pkg::fsnf_cmd_t    cmd
);

  fsnf_pkg::fsnf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsnf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != fsnf_pkg::ST_IDLE) || !rst_n;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      fsnf_pkg::ST_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = fsnf_pkg::ST_PRE;
        end
      end
      fsnf_pkg::ST_PRE: begin
        if (!status.npre_zero) begin
          if (status.out_free) begin
            cmd.emit = 1'b1;
            cmd.last = status.npre_one && !status.has_num;
          end
        end else if (!status.has_num) begin
          state_nxt = fsnf_pkg::ST_IDLE;
        end else if (status.is_dec) begin
          state_nxt = fsnf_pkg::ST_DABBLE;
        end else begin
          state_nxt = fsnf_pkg::ST_STRIP;
        end
      end
      fsnf_pkg::ST_DABBLE: begin
        if (!status.cnt_zero) begin
          cmd.dabble = 1'b1;
        end else begin
          cmd.bcd_load = 1'b1;
          state_nxt    = fsnf_pkg::ST_STRIP;
        end
      end
      fsnf_pkg::ST_STRIP: begin
        if (!status.cnt_one && status.top_zero) begin
          cmd.strip = 1'b1;
        end else begin
          state_nxt = fsnf_pkg::ST_DIGITS;
        end
      end
      fsnf_pkg::ST_DIGITS: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel_digit = 1'b1;
          cmd.last      = status.cnt_one;
          if (status.cnt_one) begin
            state_nxt = fsnf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = fsnf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/fsnf_dp.sv */
`timescale 1ns / 1ps

module fsnf_dp #(
  parameter int VALUE_WIDTH = fsnf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fsnf_pkg::CMD_W-1:0]    in_command,
  input  logic [fsnf_pkg::CHAR_W-1:0]   in_ch,
  input  logic [fsnf_pkg::ARG_W-1:0]    in_arg_value,
  input  logic                          cfg_we,
  input  logic [fsnf_pkg::CAP_W-1:0]    cfg_capacity,
  input  fsnf_pkg::fsnf_cmd_t           cmd,
  output fsnf_pkg::fsnf_status_t        status,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [fsnf_pkg::CHAR_W-1:0]   out_char,
  output logic [fsnf_pkg::CAP_W-1:0]    out_index,
  output logic                          out_last,
  output logic                          out_overflow
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int DEC_W      = 4 * DEC_DIGITS;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_W      = 4 * HEX_DIGITS;
  localparam int SW0        = (VALUE_WIDTH > DEC_W) ? VALUE_WIDTH : DEC_W;
  localparam int SW         = (SW0 > HEX_W) ? SW0 : HEX_W;
  localparam int CW         = $clog2(SW + 1);

  // Control state
  logic [fsnf_pkg::CAP_W-1:0]  cap_r;
  logic [fsnf_pkg::CAP_W-1:0]  wpos_r;
  logic                        err_r;
  logic                        pend_r;
  logic [1:0]                  npre_r;
  logic                        out_valid_r;

  // Item payload
  logic [fsnf_pkg::CHAR_W-1:0] pre0_r, pre1_r;
  logic                        has_num_r;
  logic                        clear_r;
  fsnf_pkg::fsnf_base_t        base_r;
  logic [SW-1:0]               sh_r;
  logic [DEC_W-1:0]            bcd_r;
  logic [CW-1:0]               cnt_r;

  logic [fsnf_pkg::CHAR_W-1:0] out_char_r;
  logic [fsnf_pkg::CAP_W-1:0]  out_index_r;
  logic                        out_last_r;
  logic                        out_ovf_r;

  // Decode of the incoming item
  logic [VALUE_WIDTH-1:0]      v;
  logic [VALUE_WIDTH-1:0]      num_v;
  logic                        pend_nxt;
  logic [1:0]                  dec_npre;
  logic [fsnf_pkg::CHAR_W-1:0] dec_pre0, dec_pre1;
  logic                        dec_has_num;
  logic                        dec_clear;
  fsnf_pkg::fsnf_base_t        dec_base;
  logic [SW-1:0]               sh_load;
  logic [CW-1:0]               cnt_load;

  logic [DEC_W-1:0]            bcd_adj;
  logic [DEC_W-1:0]            bcd_step;
  logic [3:0]                  dig_top;
  logic [SW-1:0]               sh_shift;
  logic [fsnf_pkg::CHAR_W-1:0] emit_char;
  logic                        ovf;

  always_comb begin
    v           = VALUE_WIDTH'(in_arg_value);
    num_v       = v;
    pend_nxt    = pend_r;
    dec_npre    = 2'd0;
    dec_pre0    = fsnf_pkg::CH_NUL;
    dec_pre1    = fsnf_pkg::CH_NUL;
    dec_has_num = 1'b0;
    dec_clear   = 1'b0;
    dec_base    = fsnf_pkg::BASE_DEC;
    case (in_command)
      fsnf_pkg::CMD_FMT: begin
        if (pend_r) begin
          pend_nxt = 1'b0;
          case (in_ch)
            fsnf_pkg::CH_LC_D: begin
              dec_has_num = 1'b1;
              if (v[VALUE_WIDTH-1]) begin
                dec_pre0 = fsnf_pkg::CH_MINUS;
                dec_npre = 2'd1;
                num_v    = (~v) + VALUE_WIDTH'(1);
              end
            end
            fsnf_pkg::CH_LC_U: begin
              dec_has_num = 1'b1;
            end
            fsnf_pkg::CH_LC_C: begin
              dec_pre0 = in_arg_value[fsnf_pkg::CHAR_W-1:0];
              dec_npre = 2'd1;
            end
            fsnf_pkg::CH_LC_S: begin
              dec_npre = 2'd0;
            end
            fsnf_pkg::CH_LC_X: begin
              dec_pre0    = fsnf_pkg::CH_ZERO;
              dec_pre1    = fsnf_pkg::CH_LC_X;
              dec_npre    = 2'd2;
              dec_has_num = 1'b1;
              dec_base    = fsnf_pkg::BASE_HEX;
            end
            fsnf_pkg::CH_LC_B: begin
              dec_pre0    = fsnf_pkg::CH_ZERO;
              dec_pre1    = fsnf_pkg::CH_LC_B;
              dec_npre    = 2'd2;
              dec_has_num = 1'b1;
              dec_base    = fsnf_pkg::BASE_BIN;
            end
            fsnf_pkg::CH_PERCENT: begin
              dec_pre0 = fsnf_pkg::CH_PERCENT;
              dec_npre = 2'd1;
            end
            default: begin
              // unknown conversion: echo it
              dec_pre0 = fsnf_pkg::CH_PERCENT;
              dec_pre1 = in_ch;
              dec_npre = 2'd2;
            end
          endcase
        end else if (in_ch == fsnf_pkg::CH_PERCENT) begin
          pend_nxt = 1'b1;
        end else begin
          dec_pre0 = in_ch;
          dec_npre = 2'd1;
        end
      end
      fsnf_pkg::CMD_STR: begin
        if (in_ch != fsnf_pkg::CH_NUL) begin
          dec_pre0 = in_ch;
          dec_npre = 2'd1;
        end
      end
      fsnf_pkg::CMD_END: begin
        pend_nxt  = 1'b0;
        dec_clear = 1'b1;
        if (pend_r) begin
          dec_pre0 = fsnf_pkg::CH_PERCENT;
          dec_pre1 = fsnf_pkg::CH_NUL;
          dec_npre = 2'd2;
        end else begin
          dec_pre0 = fsnf_pkg::CH_NUL;
          dec_npre = 2'd1;
        end
      end
      default: begin
        dec_npre = 2'd0;
      end
    endcase
  end

  always_comb begin
    if (dec_base == fsnf_pkg::BASE_HEX) begin
      sh_load  = SW'(HEX_W'(num_v)) << (SW - HEX_W);
      cnt_load = CW'(HEX_DIGITS);
    end else begin
      sh_load  = SW'(num_v) << (SW - VALUE_WIDTH);
      cnt_load = CW'(VALUE_WIDTH);
    end
  end

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
    bcd_step = {bcd_adj[DEC_W-2:0], sh_r[SW-1]};
  end

  always_comb begin
    if (base_r == fsnf_pkg::BASE_BIN) begin
      dig_top  = {3'b000, sh_r[SW-1]};
      sh_shift = sh_r << 1;
    end else begin
      dig_top  = sh_r[SW-1 -: 4];
      sh_shift = sh_r << 4;
    end
  end

  assign emit_char = cmd.sel_digit ? fsnf_pkg::hex_char(dig_top) : pre0_r;
  assign ovf       = err_r || (wpos_r >= cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= fsnf_pkg::CAP_RESET;
      wpos_r      <= '0;
      err_r       <= 1'b0;
      pend_r      <= 1'b0;
      npre_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      if (cmd.load) begin
        pend_r <= pend_nxt;
        npre_r <= dec_npre;
      end else if (cmd.emit && !cmd.sel_digit) begin
        npre_r <= npre_r - 2'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (clear_r && cmd.last) begin
          wpos_r <= '0;
          err_r  <= 1'b0;
        end else if (ovf) begin
          err_r <= 1'b1;
        end else begin
          wpos_r <= wpos_r + 16'd1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre0_r    <= dec_pre0;
      pre1_r    <= dec_pre1;
      has_num_r <= dec_has_num;
      clear_r   <= dec_clear;
      base_r    <= dec_base;
      sh_r      <= sh_load;
      cnt_r     <= cnt_load;
      bcd_r     <= '0;
    end else begin
      if (cmd.emit && !cmd.sel_digit) begin
        pre0_r <= pre1_r;
      end
      if ((cmd.emit && cmd.sel_digit) || cmd.strip) begin
        sh_r  <= sh_shift;
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.dabble) begin
        bcd_r <= bcd_step;
        sh_r  <= sh_r << 1;
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.bcd_load) begin
        sh_r  <= SW'(bcd_r) << (SW - DEC_W);
        cnt_r <= CW'(DEC_DIGITS);
      end
    end
    if (cmd.emit) begin
      out_char_r  <= ovf ? fsnf_pkg::CH_NUL : emit_char;
      out_index_r <= wpos_r;
      out_last_r  <= cmd.last;
      out_ovf_r   <= ovf;
    end
  end

  always_comb begin
    status.out_free  = !out_valid_r || !out_stall;
    status.npre_zero = (npre_r == 2'd0);
    status.npre_one  = (npre_r == 2'd1);
    status.has_num   = has_num_r;
    status.is_dec    = (base_r == fsnf_pkg::BASE_DEC);
    status.cnt_zero  = (cnt_r == '0);
    status.cnt_one   = (cnt_r == CW'(1));
    status.top_zero  = (dig_top == 4'd0);
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_index    = out_index_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

/* sv/fsnf_checker.sv */
`timescale 1ns / 1ps

module fsnf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [fsnf_pkg::CHAR_W-1:0]  out_char,
  input logic [fsnf_pkg::CAP_W-1:0]   out_index,
  input logic                         out_last,
  input logic                         out_overflow
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_index)
      && $stable(out_last) && $stable(out_overflow))
    else $error("stalled result changed");

  // Drop the character of an overflowing write.
  a_ovf_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_char == fsnf_pkg::CH_NUL)
    else $error("overflow with nonzero character");

  // One item at a time: an accepted item blocks the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind format_string_number_formatter fsnf_checker u_fsnf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char     (out_char),
  .out_index    (out_index),
  .out_last     (out_last),
  .out_overflow (out_overflow)
);

/* tb/format_char_checker.sv */
`timescale 1ns / 1ps

module format_char_checker
  import fsnf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic [ARG_W-1:0]  in_arg_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CHAR_W-1:0] out_char,
  input  logic [CAP_W-1:0]  out_index,
  input  logic              out_last,
  input  logic              out_overflow,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_capacity,
  output int                mismatch_count,
  output int                chars_pending,
  output int                chars_checked
);

  localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic [CAP_W-1:0]  idx;
    logic              last;
    logic              ovf;
  } buf_write_t;

  buf_write_t expected_chars[$];

  logic [CAP_W-1:0] capacity_reg;
  logic [CAP_W-1:0] write_pos;
  logic             pct_pending;
  logic             sticky_error;
  int               mismatches;
  int               checked;

  // Write one character to the buffer, or flag an overflow.
  task automatic write_char(input logic [CHAR_W-1:0] c);
    buf_write_t w;
    w.idx  = write_pos;
    w.last = 1'b0;
    if (sticky_error || write_pos >= capacity_reg) begin
      sticky_error = 1'b1;
      w.ovf = 1'b1;
      w.chr = CH_NUL;
    end else begin
      w.ovf = 1'b0;
      w.chr = c;
      write_pos = write_pos + CAP_W'(1);
    end
    expected_chars.push_back(w);
  endtask

  task automatic write_number(input logic [ARG_W-1:0] value, input logic [ARG_W-1:0] base);
    logic [CHAR_W-1:0] digits [0:ARG_W-1];
    logic [ARG_W-1:0]  rest;
    logic [3:0]        d;
    int                len;
    rest = value;
    len  = 0;
    do begin
      d = 4'(rest % base);
      digits[len] = (d < 4'd10) ? CH_ZERO + CHAR_W'(d) : CH_LC_A + CHAR_W'(d) - 8'd10;
      rest = rest / base;
      len++;
    end while (rest != '0);
    for (int i = len - 1; i >= 0; i--) write_char(digits[i]);
  endtask

  task automatic apply_conversion(input logic [CHAR_W-1:0] letter, input logic [ARG_W-1:0] arg);
    case (letter)
      CH_LC_D: begin
        if (arg[ARG_W-1]) begin
          write_char(CH_MINUS);
          write_number(~arg + ARG_W'(1), 10);
        end else begin
          write_number(arg, 10);
        end
      end
      CH_LC_U: write_number(arg, 10);
      CH_LC_C: write_char(arg[CHAR_W-1:0]);
      CH_LC_S: ;
      CH_LC_X: begin
        write_char(CH_ZERO);
        write_char(CH_LC_X);
        write_number(arg, 16);
      end
      CH_LC_B: begin
        write_char(CH_ZERO);
        write_char(CH_LC_B);
        write_number(arg, 2);
      end
      CH_PERCENT: write_char(CH_PERCENT);
      default: begin
        write_char(CH_PERCENT);
        write_char(letter);
      end
    endcase
  endtask

  task automatic predict_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] c,
                              input logic [ARG_W-1:0] arg);
    int first;
    first = expected_chars.size();
    case (cmd)
      CMD_FMT: begin
        if (pct_pending) begin
          pct_pending = 1'b0;
          apply_conversion(c, arg);
        end else if (c == CH_PERCENT) begin
          pct_pending = 1'b1;
        end else begin
          write_char(c);
        end
      end
      CMD_STR: if (c != CH_NUL) write_char(c);
      CMD_END: begin
        if (pct_pending) write_char(CH_PERCENT);
        write_char(CH_NUL);
        pct_pending  = 1'b0;
        write_pos    = '0;
        sticky_error = 1'b0;
      end
      default: ;
    endcase
    if (expected_chars.size() > first) expected_chars[expected_chars.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string field, input logic [CAP_W-1:0] want,
                             input logic [CAP_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    buf_write_t want;
    if (!rst_n) begin
      capacity_reg = CAP_RESET;
      write_pos    = '0;
      pct_pending  = 1'b0;
      sticky_error = 1'b0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity_reg = cfg_capacity;
      if (in_valid && !in_stall) predict_item(in_command, in_ch, in_arg_value);
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected character, expected none, actual char %0h index %0h",
                   $time, out_char, out_index);
        end else begin
          want = expected_chars.pop_front();
          check_field("char", CAP_W'(want.chr), CAP_W'(out_char));
          check_field("index", want.idx, out_index);
          check_field("last", CAP_W'(want.last), CAP_W'(out_last));
          check_field("overflow", CAP_W'(want.ovf), CAP_W'(out_overflow));
        end
      end
    end
    mismatch_count <= mismatches;
    chars_pending  <= expected_chars.size();
    chars_checked  <= checked;
  end

endmodule

/* tb/format_string_number_formatter_tb.sv */
`timescale 1ns / 1ps

module format_string_number_formatter_tb;
  import fsnf_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 20;
  localparam int HOLD_CYCLES   = 200;
  // Covers the slowest item (32-bit decimal) after the last character has left.
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 84;
  localparam int PHASES        = 6;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  // Command code the block must ignore.
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam logic [CHAR_W-1:0] CH_LC_Q = 8'h71;
  localparam logic [CHAR_W-1:0] CH_LC_Z = 8'h7a;

  // Capacity per random phase; the last phase draws a small random one.
  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] =
    '{16'd12, 16'd0, 16'd65535, 16'd256, 16'd1, 16'd40};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = CMD_FMT;
  logic [CHAR_W-1:0] in_ch = '0;
  logic [ARG_W-1:0]  in_arg_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic [CAP_W-1:0]  out_index;
  logic              out_last;
  logic              out_overflow;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_capacity = CAP_RESET;

  int mismatch_count;
  int chars_pending;
  int chars_checked;

  // Shared controls: calm turns idling off on both sides, hold_req asks the
  // receiver for one long hold-off.
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int cap_writes = 0;

  format_string_number_formatter i_dut (.*);

  format_char_checker i_checker (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("timeout after %0d ns", RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // Result side: stall at random, or hold off for a long stretch on request
  // so the block fills up and pushes back on its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one item and hold it until accepted. Valid stays high on return,
  // so back-to-back items keep it high unless the next one draws an idle gap.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] c,
                           input logic [ARG_W-1:0] arg);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      // Mostly short gaps, now and then a longer one that can outlast a whole conversion.
      repeat (($urandom_range(9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_ch        <= c;
    in_arg_value <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != CMD_IGNORED) items_sent++;
  endtask

  task automatic send_conversion(input logic [CHAR_W-1:0] letter, input logic [ARG_W-1:0] arg);
    send_item(CMD_FMT, CH_PERCENT, $urandom());
    send_item(CMD_FMT, letter, arg);
  endtask

  // Drop valid and wait until every expected character is back, then let a
  // no-result item finish too.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // Argument words biased toward the edges of the number formats.
  function automatic logic [ARG_W-1:0] rand_arg();
    logic [ARG_W-1:0] r;
    case ($urandom_range(5))
      0: r = '0;
      1: r = '1;
      2: r = {1'b1, {(ARG_W-1){1'b0}}};
      3: r = ARG_W'($urandom_range(0, 20));
      4: r = ~ARG_W'($urandom_range(0, 19));
      default: r = $urandom();
    endcase
    return r;
  endfunction

  // One format string: a few tokens, usually closed by an end item.
  task automatic send_random_format();
    int tokens;
    int kind;
    int n;
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        send_item(CMD_FMT, 8'($urandom_range(255)), $urandom());
      end else if (kind < 65) begin
        case ($urandom_range(5))
          0: send_conversion(CH_LC_D, rand_arg());
          1: send_conversion(CH_LC_U, rand_arg());
          2: send_conversion(CH_LC_C, rand_arg());
          3: send_conversion(CH_LC_X, rand_arg());
          4: send_conversion(CH_LC_B, rand_arg());
          default: send_conversion(CH_PERCENT, rand_arg());
        endcase
      end else if (kind < 80) begin
        send_conversion(CH_LC_S, $urandom());
        n = $urandom_range(0, 5);
        repeat (n) send_item(CMD_STR, 8'($urandom_range(1, 255)), $urandom());
        if ($urandom_range(1)) send_item(CMD_STR, CH_NUL, $urandom());
      end else if (kind < 88) begin
        send_conversion(8'($urandom_range(255)), rand_arg());
      end else if (kind < 94) begin
        send_item(CMD_STR, $urandom_range(1) ? CH_NUL : 8'($urandom_range(255)), $urandom());
      end else begin
        send_item(CMD_IGNORED, 8'($urandom_range(255)), $urandom());
      end
    end
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(9) == 0) send_item(CMD_FMT, CH_PERCENT, $urandom());
      send_item(CMD_END, 8'($urandom_range(255)), $urandom());
    end
  endtask

  initial begin
    int random_start;
    logic [CAP_W-1:0] cap;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset capacity: number extremes, every
    // conversion, unknown letter, string while a percent is pending.
    send_item(CMD_FMT, 8'h41, '0);
    send_conversion(CH_LC_D, 32'h8000_0000);
    send_conversion(CH_LC_D, 32'hffff_ffff);
    send_conversion(CH_LC_U, 32'hffff_ffff);
    send_conversion(CH_LC_X, '0);
    send_conversion(CH_LC_B, 32'hffff_ffff);
    send_conversion(CH_LC_C, 32'habcd_12ff);
    send_conversion(CH_PERCENT, '0);
    send_conversion(CH_LC_Q, 32'h1234_5678);
    send_item(CMD_FMT, CH_PERCENT, '0);
    send_item(CMD_STR, CH_LC_Z, '0);
    send_item(CMD_FMT, CH_LC_S, '0);
    send_item(CMD_STR, CH_LC_Q, '0);
    send_item(CMD_STR, CH_NUL, '0);
    // Zero format character is copied like any plain one.
    send_item(CMD_FMT, CH_NUL, '0);
    send_item(CMD_IGNORED, 8'hff, '1);
    // Lone percent before the end item.
    send_item(CMD_FMT, CH_PERCENT, '0);
    send_item(CMD_END, CH_NUL, '0);

    // Overflow sticks even once capacity is raised, until the next end item.
    wait_drained();
    write_capacity(16'd1);
    send_item(CMD_FMT, CH_LC_Q, '0);
    send_item(CMD_FMT, CH_LC_Z, '0);
    wait_drained();
    write_capacity(16'd65535);
    send_item(CMD_FMT, CH_LC_Q, '0);
    send_item(CMD_END, CH_NUL, '0);

    // Random phases, each under its own capacity.
    random_start = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      cap = (p == PHASES - 1) ? CAP_W'($urandom_range(2, 60)) : PHASE_CAPS[p];
      write_capacity(cap);
      hold_req = (p == 2);
      calm     = (p == 3);
      while (items_sent < random_start + (p + 1) * RANDOM_ITEMS / PHASES)
        send_random_format();
    end
    calm = 1'b0;

    wait_drained();
    $display("covered %0d items and %0d characters over %0d capacity settings",
             items_sent, chars_checked, cap_writes);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
